// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk while arst_n is high.
`define LRAC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds.
`define LRAC_NEVER(lbl, expr, msg) \
	`LRAC_ASSERT(lbl, !(expr), msg)

`endif

// ----- sv/lrac_pkg.sv -----
// ----------------------------------------------------------------------------
// lrac_pkg
// Shared constants, codes and result type of the layer compositor.
// ----------------------------------------------------------------------------
package lrac_pkg;

	localparam int LAYERS_DEF     = 16;
	localparam int COORD_BITS_DEF = 13;

	localparam int CMD_W     = 2;
	localparam int SLOT_W    = 4;
	localparam int SIZE_W    = 13;
	localparam int TEXEL_W   = 32;
	localparam int OUT_W     = 24;
	localparam int ACC_W     = 16;
	localparam int MIX_W     = 24;
	localparam int CFG_IDX_W = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOCATE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_BLEND  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 13'd480;

	localparam logic [7:0]       ALPHA_MAX = 8'd255;
	localparam logic [ACC_W-1:0] ACC_MAX   = 16'hFF00;

	typedef struct packed {
		logic [OUT_W-1:0] packed_color;
		logic [OUT_W-1:0] frame_index;
		logic             inside_frame;
		logic             covered;
		logic [OUT_W-1:0] texel_index;
	} res_t;

endpackage

// ----- sv/lrac_req_if.sv -----
// ----------------------------------------------------------------------------
// lrac_req_if
// Command channel: load, locate and blend beats with valid/ready.
// ----------------------------------------------------------------------------
interface lrac_req_if import lrac_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic [CMD_W-1:0]             cmd;
	logic [SLOT_W-1:0]            layer_slot;
	logic signed [COORD_BITS-1:0] coord_x;
	logic signed [COORD_BITS-1:0] coord_y;
	logic [SIZE_W-1:0]            width_in;
	logic [SIZE_W-1:0]            height_in;
	logic [TEXEL_W-1:0]           texel;
	logic                         pixel_start;
	logic                         final_layer;

	modport source (
		output valid, cmd, layer_slot, coord_x, coord_y, width_in, height_in,
		       texel, pixel_start, final_layer,
		input  ready
	);
	modport sink (
		input  valid, cmd, layer_slot, coord_x, coord_y, width_in, height_in,
		       texel, pixel_start, final_layer,
		output ready
	);
endinterface

// ----- sv/lrac_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lrac_rsp_if
// Result channel: locate answers and composited pixels with valid/ready.
// ----------------------------------------------------------------------------
interface lrac_rsp_if import lrac_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] packed_color;
	logic [OUT_W-1:0] frame_index;
	logic             inside_frame;
	logic             covered;
	logic [OUT_W-1:0] texel_index;

	modport source (
		output valid, packed_color, frame_index, inside_frame, covered, texel_index,
		input  ready
	);
	modport sink (
		input  valid, packed_color, frame_index, inside_frame, covered, texel_index,
		output ready
	);
endinterface

// ----- sv/lrac_cfg_if.sv -----
// ----------------------------------------------------------------------------
// lrac_cfg_if
// Register write channel: index and data with valid/ready.
// ----------------------------------------------------------------------------
interface lrac_cfg_if import lrac_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [SIZE_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/layer_rect_alpha_compositor_unit.sv -----
// ----------------------------------------------------------------------------
// layer_rect_alpha_compositor_unit
// Rectangular layer compositor: geometry RAM, coverage test, "over" blend
// into 8.8 color accumulators, and frame index of each finished pixel.
// ----------------------------------------------------------------------------
//  channel | dir | beat                                   | accepted when
//  req     | in  | cmd, slot, coords, size, texel, flags  | req.valid & req.ready
//  rsp     | out | color, frame index, inside, cover, tix | rsp.valid & rsp.ready
//  cfg     | in  | register index, data                   | cfg.valid (ready high)
//
//  One beat per cycle while the second output entry is free; a result reaches
//  rsp through stage registers s1, s2 and s3, the first loaded on the edge
//  that takes its command beat, then the output register.
//  The accumulator read-modify-write sits in stage 2 and closes within it,
//  so consecutive blends of the same pixel run back to back.
//  Reset clears the layer and stage valid bits and accumulators at once;
//  no clearing pass, commands are taken on the first edge after reset.
//  A two-entry output buffer decouples rsp: the pipeline freezes only while
//  both entries are held.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module layer_rect_alpha_compositor_unit import lrac_pkg::*; #(
	parameter int LAYERS     = LAYERS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	lrac_req_if.sink     req,
	lrac_rsp_if.source   rsp,
	lrac_cfg_if.sink     cfg
);
	localparam int IDX_W = (LAYERS > 1) ? $clog2(LAYERS) : 1;
	localparam int DW    = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 2;
	localparam int FP_W  = COORD_BITS + SIZE_W + 1;
	localparam int AR_W  = 2 * SIZE_W;
	localparam int XW    = (FP_W + 1 > AR_W + 1) ? FP_W + 1 : AR_W + 1;
	localparam int TP_W  = 2 * SIZE_W;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [SIZE_W-1:0]            w;
		logic [SIZE_W-1:0]            h;
	} geo_t;

	// Divide a blend sum by 255: reciprocal series estimate, one correction.
	function automatic logic [ACC_W-1:0] div255(input logic [MIX_W-1:0] x);
		logic [MIX_W:0]   s;
		logic [MIX_W-8:0] q0;
		logic [MIX_W+1:0] r;
		s  = {1'b0, x} + (MIX_W+1)'(x >> 8) + (MIX_W+1)'(x >> 16);
		q0 = s[MIX_W:8];
		r  = (MIX_W+2)'(x) + (MIX_W+2)'(q0) - (MIX_W+2)'({q0, 8'h00});
		return ACC_W'(q0) + {{(ACC_W-1){1'b0}}, (r >= (MIX_W+2)'(255))};
	endfunction

	// ---------------- registers and handshake ----------------
	logic [SIZE_W-1:0] fw_q, fh_q;
	logic [AR_W-1:0]   area_q;
	logic              en;
	logic              accept;
	logic              slot_ok;
	logic [IDX_W-1:0]  slot_idx;
	logic [LAYERS-1:0] geo_vld_q;
	geo_t              geo_wr, geo_rd;
	logic              out_vld_q, skid_vld_q;

	// pipeline advances whenever the second output entry is free
	assign en         = !skid_vld_q;
	assign req.ready  = en;
	assign cfg.ready  = 1'b1;
	assign accept     = req.valid && en;
	assign slot_ok    = (32'(req.layer_slot) < LAYERS);
	assign slot_idx   = IDX_W'(req.layer_slot);

	assign geo_wr = '{x: req.coord_x, y: req.coord_y, w: req.width_in, h: req.height_in};

	// layer geometry store: write on load beats, read whenever the pipeline advances
	lrac_ram #(
		.WIDTH ($bits(geo_t)),
		.DEPTH (LAYERS)
	) u_geo_ram (
		.clk   (clk),
		.we    (accept && req.cmd == CMD_LOAD && slot_ok),
		.waddr (slot_idx),
		.wdata (geo_wr),
		.re    (en),
		.raddr (slot_idx),
		.rdata (geo_rd)
	);

	// ---------------- stage 1: coverage test ----------------
	logic                         vld_s1, geo_ok_s1, start_s1, final_s1;
	logic [CMD_W-1:0]             cmd_s1;
	logic signed [COORD_BITS-1:0] px_s1, py_s1;
	logic [TEXEL_W-1:0]           tex_s1;

	logic signed [DW-1:0]   lx, ly;
	logic                   cov;
	logic signed [FP_W-1:0] fprod;
	logic [7:0]             a1;
	logic [15:0]            ta_prod [3];

	always_comb begin
		lx    = DW'(px_s1) - DW'(geo_rd.x);
		ly    = DW'(py_s1) - DW'(geo_rd.y);
		cov   = geo_ok_s1 && !lx[DW-1] && !ly[DW-1] &&
		        (lx < $signed(DW'(geo_rd.w))) && (ly < $signed(DW'(geo_rd.h)));
		fprod = py_s1 * $signed({1'b0, fw_q});
		a1    = tex_s1[31:24];
		for (int k = 0; k < 3; k++) begin
			ta_prod[k] = tex_s1[8*k +: 8] * a1;
		end
	end

	// ---------------- stage 2: blend, frame index ----------------
	logic                         vld_s2, cov_s2, start_s2, final_s2;
	logic [CMD_W-1:0]             cmd_s2;
	logic signed [COORD_BITS-1:0] px_s2;
	logic signed [FP_W-1:0]       fprod_s2;
	logic [SIZE_W-1:0]            lx_s2, ly_s2, w_s2;
	logic [7:0]                   a_s2, inv_s2;
	logic [7:0]                   t_s2  [3];
	logic [MIX_W-1:0]             ta_s2 [3];

	logic [ACC_W-1:0] acc_q    [3];
	logic [ACC_W-1:0] acc_base [3];
	logic [ACC_W-1:0] acc_nxt  [3];
	logic [MIX_W-1:0] mix_prod [3];
	logic [MIX_W-1:0] mix      [3];
	logic signed [XW-1:0] fidx;
	logic                 in_frame;
	logic [TP_W-1:0]      tprod;
	logic                 blend_go;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			acc_base[k] = start_s2 ? '0 : acc_q[k];
			mix_prod[k] = acc_base[k] * inv_s2;
			mix[k]      = mix_prod[k] + ta_s2[k];
			priority if (!cov_s2 || a_s2 == 8'd0) begin
				acc_nxt[k] = acc_base[k];
			end else if (a_s2 == ALPHA_MAX) begin
				acc_nxt[k] = {t_s2[k], 8'h00};
			end else begin
				acc_nxt[k] = div255(mix[k]);
			end
		end
		fidx     = XW'(px_s2) + XW'(fprod_s2);
		in_frame = !fidx[XW-1] && (fidx < $signed(XW'(area_q)));
		tprod    = ly_s2 * w_s2;
	end

	assign blend_go = en && vld_s2 && cmd_s2 == CMD_BLEND;

	// ---------------- stage 3: result assembly ----------------
	logic              vld_s3, cov_s3, final_s3, inside_s3;
	logic [CMD_W-1:0]  cmd_s3;
	logic [SIZE_W-1:0] lx_s3;
	logic [TP_W-1:0]   tprod_s3;
	logic [OUT_W-1:0]  fidx_s3;
	logic              res_vld;
	res_t              res;

	always_comb begin
		res     = '0;
		res_vld = 1'b0;
		if (vld_s3 && cmd_s3 == CMD_LOCATE) begin
			res_vld     = 1'b1;
			res.covered = cov_s3;
			res.texel_index = cov_s3 ? OUT_W'(tprod_s3 + TP_W'(lx_s3)) : '0;
		end else if (vld_s3 && cmd_s3 == CMD_BLEND && final_s3) begin
			res_vld          = 1'b1;
			res.packed_color = {acc_q[0][15:8], acc_q[1][15:8], acc_q[2][15:8]};
			res.frame_index  = fidx_s3;
			res.inside_frame = inside_s3;
		end
	end

	// ---------------- output register and skid entry ----------------
	res_t out_q, skid_q;

	assign rsp.valid        = out_vld_q;
	assign rsp.packed_color = out_q.packed_color;
	assign rsp.frame_index  = out_q.frame_index;
	assign rsp.inside_frame = out_q.inside_frame;
	assign rsp.covered      = out_q.covered;
	assign rsp.texel_index  = out_q.texel_index;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q       <= FRAME_WIDTH_RST;
			fh_q       <= FRAME_HEIGHT_RST;
			geo_vld_q  <= '0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
			for (int k = 0; k < 3; k++) begin
				acc_q[k] <= '0;
			end
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_FRAME_WIDTH:  fw_q <= cfg.data;
					REG_FRAME_HEIGHT: fh_q <= cfg.data;
					default: ;
				endcase
			end
			if (accept && req.cmd == CMD_LOAD && slot_ok) begin
				geo_vld_q[slot_idx] <= 1'b1;
			end
			if (en) begin
				vld_s1 <= accept;
				vld_s2 <= vld_s1;
				vld_s3 <= vld_s2;
			end
			if (blend_go) begin
				for (int k = 0; k < 3; k++) begin
					acc_q[k] <= acc_nxt[k];
				end
			end
			// drain the skid entry first, else take the new result
			if (skid_vld_q) begin
				if (rsp.ready) begin
					skid_vld_q <= 1'b0;
				end
			end else if (res_vld) begin
				if (!out_vld_q || rsp.ready) begin
					out_vld_q <= 1'b1;
				end else begin
					skid_vld_q <= 1'b1;
				end
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		area_q <= fw_q * fh_q;
		if (en) begin
			cmd_s1    <= req.cmd;
			px_s1     <= req.coord_x;
			py_s1     <= req.coord_y;
			tex_s1    <= req.texel;
			start_s1  <= req.pixel_start;
			final_s1  <= req.final_layer;
			geo_ok_s1 <= slot_ok ? geo_vld_q[slot_idx] : 1'b0;

			cmd_s2   <= cmd_s1;
			px_s2    <= px_s1;
			start_s2 <= start_s1;
			final_s2 <= final_s1;
			cov_s2   <= cov;
			lx_s2    <= lx[SIZE_W-1:0];
			ly_s2    <= ly[SIZE_W-1:0];
			w_s2     <= geo_rd.w;
			fprod_s2 <= fprod;
			a_s2     <= a1;
			inv_s2   <= ALPHA_MAX - a1;
			for (int k = 0; k < 3; k++) begin
				t_s2[k]  <= tex_s1[8*k +: 8];
				ta_s2[k] <= {ta_prod[k], 8'h7F};
			end

			cmd_s3    <= cmd_s2;
			final_s3  <= final_s2;
			cov_s3    <= cov_s2;
			lx_s3     <= lx_s2;
			tprod_s3  <= tprod;
			fidx_s3   <= fidx[OUT_W-1:0];
			inside_s3 <= in_frame;
		end
		if (skid_vld_q) begin
			if (rsp.ready) begin
				out_q <= skid_q;
			end
		end else if (res_vld) begin
			if (!out_vld_q || rsp.ready) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end
	end

	// ---------------- checks ----------------
	`LRAC_ASSERT(a_skid_behind_out, skid_vld_q |-> out_vld_q, "skid entry held without output entry")
	`LRAC_NEVER(a_acc_red_range, acc_q[2] > ACC_MAX, "red accumulator above full scale")
	`LRAC_NEVER(a_acc_blue_range, acc_q[0] > ACC_MAX, "blue accumulator above full scale")
	`LRAC_ASSERT(a_load_marks_valid, accept && req.cmd == CMD_LOAD && slot_ok |=> geo_vld_q[$past(slot_idx)], "loaded layer not marked valid")
	`LRAC_ASSERT(a_opaque_replace, blend_go && cov_s2 && a_s2 == ALPHA_MAX |=> acc_q[2][15:8] == $past(t_s2[2]) && acc_q[2][7:0] == 8'h00, "opaque texel did not replace red")

endmodule

// ----- sv/lrac_ram.sv -----
// ----------------------------------------------------------------------------
// lrac_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module lrac_ram #(
	parameter int  WIDTH = 8,
	parameter int  DEPTH = 16,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
